>>> src/polygon_store_distance_query_defines.svh
// Assertion macros for the polygon store with distance query.
`ifndef POLYGON_STORE_DISTANCE_QUERY_DEFINES_SVH
`define POLYGON_STORE_DISTANCE_QUERY_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define PSDQ_ASSERT_NOW(lbl, clk, rst, cond, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define PSDQ_ASSERT_NEXT(lbl, clk, rst, cond, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

>>> src/psdq_pkg.sv
// Types, constants and helper functions shared by the polygon store.
`default_nettype none

package psdq_pkg;

   localparam int WIDE_W = 40;
   localparam int DIFF_W = 31;
   localparam int MA_W   = 34;
   localparam int MB_W   = 32;
   localparam int P_W    = 66;

   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic signed [DIFF_W-1:0] diff_type;

   localparam wide_type DIFF_LIM = wide_type'(1073741823);
   localparam logic [23:0] DIST_MAX = 24'hFFFFFF;

   localparam logic [5:0] PROJ_DIV_STEPS = 6'd31;
   localparam logic [5:0] NORM_DIV_STEPS = 6'd29;
   localparam logic [63:0] SQRT_TOP_BIT = 64'h4000_0000_0000_0000;

   localparam logic [2:0] MODE_CLEAR     = 3'd0;
   localparam logic [2:0] MODE_APPEND    = 3'd1;
   localparam logic [2:0] MODE_TRANSLATE = 3'd2;
   localparam logic [2:0] MODE_ROTATE    = 3'd3;
   localparam logic [2:0] MODE_QUERY     = 3'd4;
   localparam logic [2:0] MODE_READ      = 3'd5;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      PLAN_ROT,
      PLAN_EDGE,
      PLAN_PROJ,
      PLAN_DIST,
      PLAN_NORM
   } plan_type;

   typedef enum logic [1:0] {
      ACC_SET,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef struct packed {
      logic [1:0] asel;
      logic       bsel;
      acc_op_type op;
      logic       dst;
      logic       last;
   } mac_step_type;

   function automatic diff_type satd(input wide_type v);
      wide_type r;
      if (v > DIFF_LIM) begin
         r = DIFF_LIM;
      end else if (v < -DIFF_LIM) begin
         r = -DIFF_LIM;
      end else begin
         r = v;
      end
      return diff_type'(r);
   endfunction

   function automatic mac_step_type mac_step(input plan_type p, input logic [1:0] s);
      mac_step_type m;
      m = '{asel: 2'd0, bsel: 1'b0, op: ACC_SET, dst: 1'b0, last: 1'b1};
      case (p)
         PLAN_ROT: begin
            case (s)
               2'd0: m = '{asel: 2'd0, bsel: 1'b0, op: ACC_SET, dst: 1'b0, last: 1'b0};
               2'd1: m = '{asel: 2'd1, bsel: 1'b1, op: ACC_SUB, dst: 1'b0, last: 1'b0};
               2'd2: m = '{asel: 2'd0, bsel: 1'b1, op: ACC_SET, dst: 1'b1, last: 1'b0};
               default: m = '{asel: 2'd1, bsel: 1'b0, op: ACC_ADD, dst: 1'b1, last: 1'b1};
            endcase
         end
         PLAN_EDGE: begin
            case (s)
               2'd0: m = '{asel: 2'd0, bsel: 1'b0, op: ACC_SET, dst: 1'b0, last: 1'b0};
               2'd1: m = '{asel: 2'd1, bsel: 1'b1, op: ACC_ADD, dst: 1'b0, last: 1'b0};
               2'd2: m = '{asel: 2'd2, bsel: 1'b0, op: ACC_SET, dst: 1'b1, last: 1'b0};
               default: m = '{asel: 2'd3, bsel: 1'b1, op: ACC_ADD, dst: 1'b1, last: 1'b1};
            endcase
         end
         PLAN_PROJ: begin
            case (s)
               2'd0: m = '{asel: 2'd0, bsel: 1'b0, op: ACC_SET, dst: 1'b0, last: 1'b0};
               default: m = '{asel: 2'd1, bsel: 1'b0, op: ACC_SET, dst: 1'b1, last: 1'b1};
            endcase
         end
         PLAN_DIST: begin
            case (s)
               2'd0: m = '{asel: 2'd0, bsel: 1'b0, op: ACC_SET, dst: 1'b0, last: 1'b0};
               default: m = '{asel: 2'd1, bsel: 1'b1, op: ACC_ADD, dst: 1'b0, last: 1'b1};
            endcase
         end
         PLAN_NORM: begin
            case (s)
               2'd0: m = '{asel: 2'd0, bsel: 1'b0, op: ACC_SET, dst: 1'b0, last: 1'b0};
               default: m = '{asel: 2'd1, bsel: 1'b1, op: ACC_SET, dst: 1'b1, last: 1'b1};
            endcase
         end
         default: m = '{asel: 2'd0, bsel: 1'b0, op: ACC_SET, dst: 1'b0, last: 1'b1};
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

>>> src/polygon_store_distance_query.sv
// Polygon store with vertex edit modes and point-to-boundary distance query.
//
// The block holds one closed polygon in a single-port vertex memory and works on one item at a
// time, driven by a sequencer that shares one multiplier, a divider that yields one quotient bit
// per cycle and a square root unit that yields one result bit per cycle. A translate or rotate
// reads each vertex and writes it back, one vertex after the other. A distance query takes each
// edge in turn: the edge products, then the divide of the projection, which dominates (an edge
// whose projection clamps to an end skips it, and the closing edge also skips its vertex read),
// then the squared distance; after the last edge come the final square root, the normal and the result. A new
// item is taken while the previous result waits in the output register. The vertex memory holds
// no reset value; only vertices below the count are read.
`default_nettype none

`include "polygon_store_distance_query_defines.svh"

module polygon_store_distance_query #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_WIDTH  = 24
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [2:0]         req_mode,
   input  wire  signed [23:0] req_x_in,
   input  wire  signed [23:0] req_y_in,
   input  wire  signed [15:0] req_cos_val,
   input  wire  signed [15:0] req_sin_val,
   input  wire  [5:0]         req_index,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_count,
   output logic signed [23:0] rsp_x_out,
   output logic signed [23:0] rsp_y_out,
   output logic [23:0]        rsp_distance,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic [5:0]         rsp_edge_index
);

   import psdq_pkg::*;

   localparam int AW    = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);
   localparam wide_type CRD_MAX =
      {{(WIDE_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam wide_type CRD_MIN = ~CRD_MAX;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DONE, S_RDV, S_TR_RD, S_TR_WT, S_ROT_WR, S_MAC, S_DIV, S_SQ,
      S_Q_FIRST, S_Q_NEXT, S_Q_NWT, S_Q_EDGE, S_Q_PROJ, S_Q_PMUL, S_Q_PADD,
      S_Q_DIST, S_Q_CMP, S_Q_NRM0, S_Q_NRM1, S_Q_NRM2, S_Q_NRM3,
      S_Q_NX, S_Q_NXS, S_Q_NY, S_Q_NYS
   } state_type;

   function automatic coord_type sat_coord(input wide_type v);
      wide_type r;
      if (v > CRD_MAX) begin
         r = CRD_MAX;
      end else if (v < CRD_MIN) begin
         r = CRD_MIN;
      end else begin
         r = v;
      end
      return coord_type'(r);
   endfunction

   state_type state_ff, ret_ff;
   logic [CNT_W-1:0] count_ff;
   logic [AW-1:0] i_ff, bi_ff;
   logic [2:0] mode_ff;
   logic signed [23:0] xi_ff, yi_ff;
   logic signed [15:0] cv_ff, sv_ff;
   coord_type x0_ff, y0_ff, x1_ff, y1_ff, fx_ff, fy_ff;
   wide_type px_ff, py_ff;
   logic signed [MA_W-1:0] u0_ff, u1_ff, u2_ff, u3_ff;
   logic signed [MB_W-1:0] w0_ff, w1_ff;
   logic signed [P_W-1:0] mp_ff, acc0_ff, acc1_ff;
   plan_type plan_ff;
   logic [1:0] mstep_ff;
   logic phase_ff;
   logic [63:0] div_r_ff;
   logic [62:0] div_d_ff, len2_ff, best_ff;
   logic [31:0] div_q_ff;
   logic [5:0] div_cnt_ff;
   logic div_first_ff;
   logic [63:0] sq_v_ff, sq_res_ff, sq_bit_ff;

   status_type res_status_ff;
   logic signed [23:0] res_x_ff, res_y_ff;
   logic [23:0] res_dist_ff;
   logic signed [15:0] res_nx_ff, res_ny_ff;
   logic [5:0] res_edge_ff;

   logic rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   logic [6:0] rsp_count_ff;
   logic signed [23:0] rsp_x_ff, rsp_y_ff;
   logic [23:0] rsp_dist_ff;
   logic signed [15:0] rsp_nx_ff, rsp_ny_ff;
   logic [5:0] rsp_edge_ff;

   logic [2*COORD_WIDTH-1:0] vertex_mem [MAX_VERTICES];
   logic [2*COORD_WIDTH-1:0] rdata_ff;
   logic mem_rd_en, mem_wr_en;
   logic [AW-1:0] mem_rd_addr, mem_wr_addr;
   coord_type mem_wr_x, mem_wr_y;

   logic accept, i_last, b_last, take_new;
   logic [AW-1:0] bj;
   coord_type rd_x, rd_y;
   wide_type rd_xw, rd_yw, xi_w, yi_w, x0_w, y0_w, x1_w, y1_w;
   wide_type rot_rx, rot_ry;
   logic signed [P_W-1:0] rot_tx, rot_ty, proj_tx, proj_ty;
   diff_type q_bx, q_by, q_ax, q_ay, q_ex, q_ey, q_nx, q_ny;
   mac_step_type mstep;
   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic [62:0] d2, best_new, l2_sum;
   logic [63:0] div_rs, sq_t;
   logic [31:0] div_qs;
   logic div_ge;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   assign rd_x  = coord_type'(rdata_ff[2*COORD_WIDTH-1:COORD_WIDTH]);
   assign rd_y  = coord_type'(rdata_ff[COORD_WIDTH-1:0]);
   assign rd_xw = wide_type'(rd_x);
   assign rd_yw = wide_type'(rd_y);
   assign xi_w  = wide_type'(xi_ff);
   assign yi_w  = wide_type'(yi_ff);
   assign x0_w  = wide_type'(x0_ff);
   assign y0_w  = wide_type'(y0_ff);
   assign x1_w  = wide_type'(x1_ff);
   assign y1_w  = wide_type'(y1_ff);

   assign i_last = ((CNT_W'(i_ff) + CNT_W'(1)) == count_ff);
   assign b_last = ((CNT_W'(bi_ff) + CNT_W'(1)) == count_ff);
   assign bj     = b_last ? '0 : bi_ff + AW'(1);

   assign rot_tx = (acc0_ff + P_W'(8192)) >>> 14;
   assign rot_ty = (acc1_ff + P_W'(8192)) >>> 14;
   assign rot_rx = wide_type'(rot_tx);
   assign rot_ry = wide_type'(rot_ty);
   assign proj_tx = (acc0_ff + (P_W'(1) <<< 29)) >>> 30;
   assign proj_ty = (acc1_ff + (P_W'(1) <<< 29)) >>> 30;

   assign q_bx = satd(x1_w - x0_w);
   assign q_by = satd(y1_w - y0_w);
   assign q_ax = satd(xi_w - x0_w);
   assign q_ay = satd(yi_w - y0_w);
   assign q_ex = satd(xi_w - px_ff);
   assign q_ey = satd(yi_w - py_ff);
   assign q_nx = satd(rd_yw - y0_w);
   assign q_ny = satd(x0_w - rd_xw);

   assign mstep = mac_step(plan_ff, mstep_ff);
   always_comb begin
      case (mstep.asel)
         2'd0:    mul_a = u0_ff;
         2'd1:    mul_a = u1_ff;
         2'd2:    mul_a = u2_ff;
         default: mul_a = u3_ff;
      endcase
      mul_b = mstep.bsel ? w1_ff : w0_ff;
   end

   assign d2       = acc0_ff[62:0];
   assign take_new = (i_ff == '0) || (d2 < best_ff);
   assign best_new = take_new ? d2 : best_ff;
   assign l2_sum   = acc0_ff[62:0] + acc1_ff[62:0];

   assign div_rs = div_first_ff ? div_r_ff : {div_r_ff[62:0], 1'b0};
   assign div_qs = div_first_ff ? div_q_ff : {div_q_ff[30:0], 1'b0};
   assign div_ge = (div_rs >= {1'b0, div_d_ff});
   assign sq_t   = sq_res_ff + sq_bit_ff;

   always_comb begin
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = i_ff;
      mem_wr_x    = sat_coord(rd_xw + xi_w);
      mem_wr_y    = sat_coord(rd_yw + yi_w);
      case (state_ff)
         S_IDLE: begin
            if (accept && req_mode == MODE_APPEND && count_ff < CNT_MAX) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = AW'(count_ff);
               mem_wr_x    = sat_coord(wide_type'(req_x_in));
               mem_wr_y    = sat_coord(wide_type'(req_y_in));
            end
            if (accept && req_mode == MODE_QUERY) begin
               mem_rd_en = 1'b1;
            end
            if (accept && req_mode == MODE_READ) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(req_index);
            end
         end
         S_TR_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = i_ff;
         end
         S_TR_WT: begin
            mem_wr_en = (mode_ff == MODE_TRANSLATE);
         end
         S_ROT_WR: begin
            mem_wr_en = 1'b1;
            mem_wr_x  = sat_coord(xi_w + rot_rx);
            mem_wr_y  = sat_coord(yi_w + rot_ry);
         end
         S_Q_NEXT: begin
            mem_rd_en   = !i_last;
            mem_rd_addr = i_ff + AW'(1);
         end
         S_Q_NRM0: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = bi_ff;
         end
         S_Q_NRM1: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = bj;
         end
         default: begin
            mem_rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         vertex_mem[mem_wr_addr] <= {mem_wr_x, mem_wr_y};
      end
      if (mem_rd_en) begin
         rdata_ff <= vertex_mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  mode_ff       <= req_mode;
                  xi_ff         <= req_x_in;
                  yi_ff         <= req_y_in;
                  cv_ff         <= req_cos_val;
                  sv_ff         <= req_sin_val;
                  i_ff          <= '0;
                  res_x_ff      <= '0;
                  res_y_ff      <= '0;
                  res_nx_ff     <= '0;
                  res_ny_ff     <= '0;
                  res_edge_ff   <= '0;
                  case (req_mode)
                     MODE_CLEAR: begin
                        count_ff      <= '0;
                        res_status_ff <= ST_OK;
                        res_dist_ff   <= '0;
                        state_ff      <= S_DONE;
                     end
                     MODE_APPEND: begin
                        res_dist_ff <= '0;
                        state_ff    <= S_DONE;
                        if (count_ff >= CNT_MAX) begin
                           res_status_ff <= ST_FULL;
                        end else begin
                           res_status_ff <= ST_OK;
                           count_ff      <= count_ff + CNT_W'(1);
                        end
                     end
                     MODE_TRANSLATE, MODE_ROTATE: begin
                        res_status_ff <= ST_OK;
                        res_dist_ff   <= '0;
                        state_ff      <= (count_ff != '0) ? S_TR_RD : S_DONE;
                     end
                     MODE_QUERY: begin
                        if (count_ff == '0) begin
                           res_status_ff <= ST_EMPTY;
                           res_dist_ff   <= DIST_MAX;
                           state_ff      <= S_DONE;
                        end else begin
                           res_status_ff <= ST_OK;
                           res_dist_ff   <= '0;
                           state_ff      <= S_Q_FIRST;
                        end
                     end
                     MODE_READ: begin
                        res_dist_ff <= '0;
                        if (32'(req_index) >= 32'(count_ff)) begin
                           res_status_ff <= ST_RANGE;
                           state_ff      <= S_DONE;
                        end else begin
                           res_status_ff <= ST_OK;
                           state_ff      <= S_RDV;
                        end
                     end
                     default: begin
                        res_status_ff <= ST_OK;
                        res_dist_ff   <= '0;
                        state_ff      <= S_DONE;
                     end
                  endcase
               end
            end
            S_RDV: begin
               res_x_ff <= 24'(rd_xw);
               res_y_ff <= 24'(rd_yw);
               state_ff <= S_DONE;
            end
            S_TR_RD: begin
               state_ff <= S_TR_WT;
            end
            S_TR_WT: begin
               if (mode_ff == MODE_TRANSLATE) begin
                  i_ff     <= i_ff + AW'(1);
                  state_ff <= i_last ? S_DONE : S_TR_RD;
               end else begin
                  u0_ff    <= MA_W'(rd_xw - xi_w);
                  u1_ff    <= MA_W'(rd_yw - yi_w);
                  w0_ff    <= MB_W'(cv_ff);
                  w1_ff    <= MB_W'(sv_ff);
                  plan_ff  <= PLAN_ROT;
                  mstep_ff <= '0;
                  phase_ff <= 1'b0;
                  ret_ff   <= S_ROT_WR;
                  state_ff <= S_MAC;
               end
            end
            S_ROT_WR: begin
               i_ff     <= i_ff + AW'(1);
               state_ff <= i_last ? S_DONE : S_TR_RD;
            end
            S_MAC: begin
               if (!phase_ff) begin
                  mp_ff    <= mul_a * mul_b;
                  phase_ff <= 1'b1;
               end else begin
                  phase_ff <= 1'b0;
                  case (mstep.op)
                     ACC_ADD: begin
                        if (mstep.dst) acc1_ff <= acc1_ff + mp_ff;
                        else acc0_ff <= acc0_ff + mp_ff;
                     end
                     ACC_SUB: begin
                        if (mstep.dst) acc1_ff <= acc1_ff - mp_ff;
                        else acc0_ff <= acc0_ff - mp_ff;
                     end
                     default: begin
                        if (mstep.dst) acc1_ff <= mp_ff;
                        else acc0_ff <= mp_ff;
                     end
                  endcase
                  if (mstep.last) begin
                     state_ff <= ret_ff;
                  end else begin
                     mstep_ff <= mstep_ff + 2'd1;
                  end
               end
            end
            S_DIV: begin
               div_r_ff     <= div_ge ? div_rs - {1'b0, div_d_ff} : div_rs;
               div_q_ff     <= div_ge ? (div_qs | 32'd1) : div_qs;
               div_first_ff <= 1'b0;
               div_cnt_ff   <= div_cnt_ff - 6'd1;
               if (div_cnt_ff == 6'd1) begin
                  state_ff <= ret_ff;
               end
            end
            S_SQ: begin
               if (sq_v_ff >= sq_t) begin
                  sq_v_ff   <= sq_v_ff - sq_t;
                  sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_res_ff <= sq_res_ff >> 1;
               end
               sq_bit_ff <= sq_bit_ff >> 2;
               if (sq_bit_ff == 64'd1) begin
                  state_ff <= ret_ff;
               end
            end
            S_Q_FIRST: begin
               fx_ff    <= rd_x;
               fy_ff    <= rd_y;
               x0_ff    <= rd_x;
               y0_ff    <= rd_y;
               state_ff <= S_Q_NEXT;
            end
            S_Q_NEXT: begin
               if (i_last) begin
                  x1_ff    <= fx_ff;
                  y1_ff    <= fy_ff;
                  state_ff <= S_Q_EDGE;
               end else begin
                  state_ff <= S_Q_NWT;
               end
            end
            S_Q_NWT: begin
               x1_ff    <= rd_x;
               y1_ff    <= rd_y;
               state_ff <= S_Q_EDGE;
            end
            S_Q_EDGE: begin
               u0_ff    <= MA_W'(q_bx);
               u1_ff    <= MA_W'(q_by);
               u2_ff    <= MA_W'(q_ax);
               u3_ff    <= MA_W'(q_ay);
               w0_ff    <= MB_W'(q_bx);
               w1_ff    <= MB_W'(q_by);
               plan_ff  <= PLAN_EDGE;
               mstep_ff <= '0;
               phase_ff <= 1'b0;
               ret_ff   <= S_Q_PROJ;
               state_ff <= S_MAC;
            end
            S_Q_PROJ: begin
               if (acc0_ff == '0 || acc1_ff[P_W-1] || acc1_ff == '0) begin
                  px_ff    <= x0_w;
                  py_ff    <= y0_w;
                  state_ff <= S_Q_DIST;
               end else if (acc1_ff >= acc0_ff) begin
                  px_ff    <= x1_w;
                  py_ff    <= y1_w;
                  state_ff <= S_Q_DIST;
               end else begin
                  div_r_ff     <= 64'(acc1_ff[62:0]);
                  div_d_ff     <= acc0_ff[62:0];
                  div_q_ff     <= '0;
                  div_first_ff <= 1'b1;
                  div_cnt_ff   <= PROJ_DIV_STEPS;
                  ret_ff       <= S_Q_PMUL;
                  state_ff     <= S_DIV;
               end
            end
            S_Q_PMUL: begin
               w0_ff    <= $signed(div_q_ff);
               plan_ff  <= PLAN_PROJ;
               mstep_ff <= '0;
               phase_ff <= 1'b0;
               ret_ff   <= S_Q_PADD;
               state_ff <= S_MAC;
            end
            S_Q_PADD: begin
               px_ff    <= x0_w + wide_type'(proj_tx);
               py_ff    <= y0_w + wide_type'(proj_ty);
               state_ff <= S_Q_DIST;
            end
            S_Q_DIST: begin
               u0_ff    <= MA_W'(q_ex);
               u1_ff    <= MA_W'(q_ey);
               w0_ff    <= MB_W'(q_ex);
               w1_ff    <= MB_W'(q_ey);
               plan_ff  <= PLAN_DIST;
               mstep_ff <= '0;
               phase_ff <= 1'b0;
               ret_ff   <= S_Q_CMP;
               state_ff <= S_MAC;
            end
            S_Q_CMP: begin
               best_ff <= best_new;
               if (take_new) begin
                  bi_ff <= i_ff;
               end
               x0_ff <= x1_ff;
               y0_ff <= y1_ff;
               if (i_last) begin
                  sq_v_ff   <= 64'(best_new);
                  sq_res_ff <= '0;
                  sq_bit_ff <= SQRT_TOP_BIT;
                  ret_ff    <= S_Q_NRM0;
                  state_ff  <= S_SQ;
               end else begin
                  i_ff     <= i_ff + AW'(1);
                  state_ff <= S_Q_NEXT;
               end
            end
            S_Q_NRM0: begin
               res_dist_ff <= (sq_res_ff > 64'(DIST_MAX)) ? DIST_MAX : 24'(sq_res_ff);
               state_ff    <= S_Q_NRM1;
            end
            S_Q_NRM1: begin
               x0_ff    <= rd_x;
               y0_ff    <= rd_y;
               state_ff <= S_Q_NRM2;
            end
            S_Q_NRM2: begin
               u0_ff    <= MA_W'(q_nx);
               u1_ff    <= MA_W'(q_ny);
               w0_ff    <= MB_W'(q_nx);
               w1_ff    <= MB_W'(q_ny);
               plan_ff  <= PLAN_NORM;
               mstep_ff <= '0;
               phase_ff <= 1'b0;
               ret_ff   <= S_Q_NRM3;
               state_ff <= S_MAC;
            end
            S_Q_NRM3: begin
               if (l2_sum == '0) begin
                  res_edge_ff <= 6'(bi_ff);
                  state_ff    <= S_DONE;
               end else begin
                  len2_ff      <= l2_sum;
                  div_r_ff     <= 64'(acc0_ff[62:0]);
                  div_d_ff     <= l2_sum;
                  div_q_ff     <= '0;
                  div_first_ff <= 1'b1;
                  div_cnt_ff   <= NORM_DIV_STEPS;
                  ret_ff       <= S_Q_NX;
                  state_ff     <= S_DIV;
               end
            end
            S_Q_NX: begin
               sq_v_ff   <= 64'(div_q_ff);
               sq_res_ff <= '0;
               sq_bit_ff <= SQRT_TOP_BIT;
               ret_ff    <= S_Q_NXS;
               state_ff  <= S_SQ;
            end
            S_Q_NXS: begin
               res_nx_ff    <= u0_ff[MA_W-1] ? -16'(sq_res_ff) : 16'(sq_res_ff);
               div_r_ff     <= 64'(acc1_ff[62:0]);
               div_d_ff     <= len2_ff;
               div_q_ff     <= '0;
               div_first_ff <= 1'b1;
               div_cnt_ff   <= NORM_DIV_STEPS;
               ret_ff       <= S_Q_NY;
               state_ff     <= S_DIV;
            end
            S_Q_NY: begin
               sq_v_ff   <= 64'(div_q_ff);
               sq_res_ff <= '0;
               sq_bit_ff <= SQRT_TOP_BIT;
               ret_ff    <= S_Q_NYS;
               state_ff  <= S_SQ;
            end
            S_Q_NYS: begin
               res_ny_ff   <= u1_ff[MA_W-1] ? -16'(sq_res_ff) : 16'(sq_res_ff);
               res_edge_ff <= 6'(bi_ff);
               state_ff    <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_count_ff  <= 7'(count_ff);
                  rsp_x_ff      <= res_x_ff;
                  rsp_y_ff      <= res_y_ff;
                  rsp_dist_ff   <= res_dist_ff;
                  rsp_nx_ff     <= res_nx_ff;
                  rsp_ny_ff     <= res_ny_ff;
                  rsp_edge_ff   <= res_edge_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_x_out      = rsp_x_ff;
   assign rsp_y_out      = rsp_y_ff;
   assign rsp_distance   = rsp_dist_ff;
   assign rsp_normal_x   = rsp_nx_ff;
   assign rsp_normal_y   = rsp_ny_ff;
   assign rsp_edge_index = rsp_edge_ff;

   `PSDQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_MAX, "vertex count exceeds store size")
   `PSDQ_ASSERT_NEXT(a_accept_busy, clock, reset, accept, state_ff != S_IDLE, "accepted item left no work")
   `PSDQ_ASSERT_NEXT(a_done_emits, clock, reset, state_ff == S_DONE && !rsp_valid_ff, rsp_valid_ff, "finished item not presented")

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the polygon store with point-to-boundary distance query.
`timescale 1ns / 1ps

module testbench;
   import psdq_pkg::*;

   class polygon_scoreboard;
      typedef struct {
         logic [1:0]  status;
         logic [6:0]  count;
         logic [23:0] x_out;
         logic [23:0] y_out;
         logic [23:0] distance;
         logic [15:0] normal_x;
         logic [15:0] normal_y;
         logic [5:0]  edge_idx;
      } result_type;

      longint      vx[64];
      longint      vy[64];
      int unsigned vcount;
      result_type  expected_q[$];
      int          errors;

      function new();
         vcount = 0;
         errors = 0;
      endfunction

      function longint clamp_coord(longint v);
         if (v > 64'sd8388607) return 64'sd8388607;
         if (v < -64'sd8388608) return -64'sd8388608;
         return v;
      endfunction

      function longint clamp_diff(longint v);
         if (v > 64'sd1073741823) return 64'sd1073741823;
         if (v < -64'sd1073741823) return -64'sd1073741823;
         return v;
      endfunction

      function longint unsigned scaled_ratio(longint unsigned num, longint unsigned den,
                                              int bits);
         longint unsigned q;
         longint unsigned r;
         q = 0;
         r = num;
         if (r >= den) begin
            q = 1;
            r = r - den;
         end
         for (int k = 0; k < bits; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
               r = r - den;
               q = q | 1;
            end
         end
         return q;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res;
         longint unsigned bitv;
         res = 0;
         bitv = 64'h4000_0000_0000_0000;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function longint unit_component(longint c, longint unsigned l2);
         longint unsigned mag;
         mag = int_sqrt(scaled_ratio(longint'(c * c), l2, 28));
         return (c < 0) ? -longint'(mag) : longint'(mag);
      endfunction

      function void note_item(logic [2:0] mode, longint xi, longint yi, longint cv,
                              longint sv, int unsigned idx);
         result_type r;
         int unsigned n;
         int unsigned j;
         int unsigned bi;
         int unsigned bj;
         longint bx, by, ax, ay, dot, px, py, ex, ey, t, nx, ny, dx, dy;
         longint unsigned len2, d2, best, l2, root;
         r = '{default: '0};
         n = vcount;
         best = 0;
         bi = 0;
         case (mode)
            MODE_CLEAR: vcount = 0;
            MODE_APPEND: begin
               if (n >= 64) begin
                  r.status = ST_FULL;
               end else begin
                  vx[n] = clamp_coord(xi);
                  vy[n] = clamp_coord(yi);
                  vcount = n + 1;
               end
            end
            MODE_TRANSLATE: begin
               for (int i = 0; i < n; i++) begin
                  vx[i] = clamp_coord(vx[i] + xi);
                  vy[i] = clamp_coord(vy[i] + yi);
               end
            end
            MODE_ROTATE: begin
               for (int i = 0; i < n; i++) begin
                  dx = vx[i] - xi;
                  dy = vy[i] - yi;
                  vx[i] = clamp_coord(xi + ((dx * cv - dy * sv + 8192) >>> 14));
                  vy[i] = clamp_coord(yi + ((dx * sv + dy * cv + 8192) >>> 14));
               end
            end
            MODE_QUERY: begin
               if (n == 0) begin
                  r.status = ST_EMPTY;
                  r.distance = DIST_MAX;
               end else begin
                  for (int i = 0; i < n; i++) begin
                     j = (i + 1 == n) ? 0 : i + 1;
                     bx = clamp_diff(vx[j] - vx[i]);
                     by = clamp_diff(vy[j] - vy[i]);
                     ax = clamp_diff(xi - vx[i]);
                     ay = clamp_diff(yi - vy[i]);
                     len2 = bx * bx + by * by;
                     dot = ax * bx + ay * by;
                     if (len2 == 0 || dot <= 0) begin
                        px = vx[i];
                        py = vy[i];
                     end else if (longint'(len2) <= dot) begin
                        px = vx[j];
                        py = vy[j];
                     end else begin
                        t = scaled_ratio(dot, len2, 30);
                        px = vx[i] + ((bx * t + 64'sd536870912) >>> 30);
                        py = vy[i] + ((by * t + 64'sd536870912) >>> 30);
                     end
                     ex = clamp_diff(xi - px);
                     ey = clamp_diff(yi - py);
                     d2 = ex * ex + ey * ey;
                     if (i == 0 || d2 < best) begin
                        best = d2;
                        bi = i;
                     end
                  end
                  root = int_sqrt(best);
                  r.distance = (root > 64'd16777215) ? DIST_MAX : root[23:0];
                  bj = (bi + 1 == n) ? 0 : bi + 1;
                  nx = clamp_diff(vy[bj] - vy[bi]);
                  ny = clamp_diff(vx[bi] - vx[bj]);
                  l2 = nx * nx + ny * ny;
                  if (l2 != 0) begin
                     r.normal_x = 16'(unit_component(nx, l2));
                     r.normal_y = 16'(unit_component(ny, l2));
                  end
                  r.edge_idx = 6'(bi);
               end
            end
            MODE_READ: begin
               if (idx >= n) begin
                  r.status = ST_RANGE;
               end else begin
                  r.x_out = 24'(vx[idx]);
                  r.y_out = 24'(vy[idx]);
               end
            end
            default: ;
         endcase
         r.count = 7'(vcount);
         expected_q.push_back(r);
      endfunction

      task report(string field, logic [31:0] got, logic [31:0] want);
         errors++;
         if (errors < 60) $display("mismatch on %s: got %h, expected %h", field, got, want);
      endtask

      task check_result(result_type got);
         result_type e;
         if (expected_q.size() == 0) begin
            report("unexpected result", 0, 0);
            return;
         end
         e = expected_q.pop_front();
         if (got.status !== e.status) report("status", got.status, e.status);
         if (got.count !== e.count) report("count", got.count, e.count);
         if (got.x_out !== e.x_out) report("x_out", got.x_out, e.x_out);
         if (got.y_out !== e.y_out) report("y_out", got.y_out, e.y_out);
         if (got.distance !== e.distance) report("distance", got.distance, e.distance);
         if (got.normal_x !== e.normal_x) report("normal_x", got.normal_x, e.normal_x);
         if (got.normal_y !== e.normal_y) report("normal_y", got.normal_y, e.normal_y);
         if (got.edge_idx !== e.edge_idx) report("edge_index", got.edge_idx, e.edge_idx);
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_mode;
   logic signed [23:0] req_x_in;
   logic signed [23:0] req_y_in;
   logic signed [15:0] req_cos_val;
   logic signed [15:0] req_sin_val;
   logic [5:0]         req_index;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic [6:0]         rsp_count;
   logic signed [23:0] rsp_x_out;
   logic signed [23:0] rsp_y_out;
   logic [23:0]        rsp_distance;
   logic signed [15:0] rsp_normal_x;
   logic signed [15:0] rsp_normal_y;
   logic [5:0]         rsp_edge_index;

   polygon_scoreboard sb;
   bit idle_on;
   bit stall_on;
   bit hold_off;
   int sent;

   polygon_store_distance_query uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_x_in(req_x_in), .req_y_in(req_y_in), .req_cos_val(req_cos_val),
      .req_sin_val(req_sin_val), .req_index(req_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_count(rsp_count), .rsp_x_out(rsp_x_out), .rsp_y_out(rsp_y_out),
      .rsp_distance(rsp_distance), .rsp_normal_x(rsp_normal_x),
      .rsp_normal_y(rsp_normal_y), .rsp_edge_index(rsp_edge_index)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #200_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      polygon_scoreboard::result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status = rsp_status;
         got.count = rsp_count;
         got.x_out = rsp_x_out;
         got.y_out = rsp_y_out;
         got.distance = rsp_distance;
         got.normal_x = rsp_normal_x;
         got.normal_y = rsp_normal_y;
         got.edge_idx = rsp_edge_index;
         sb.check_result(got);
      end
   end

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            rsp_stall <= stall_on && ($urandom_range(0, 99) < 10);
         end
      end
   end

   task send_item(logic [2:0] m, logic signed [23:0] x, logic signed [23:0] y,
                  logic signed [15:0] c, logic signed [15:0] s, logic [5:0] ix);
      req_valid <= 1'b1;
      req_mode <= m;
      req_x_in <= x;
      req_y_in <= y;
      req_cos_val <= c;
      req_sin_val <= s;
      req_index <= ix;
      do @(posedge clock); while (req_stall);
      sb.note_item(m, longint'(x), longint'(y), longint'(c), longint'(s), ix);
      sent++;
      if (idle_on && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function logic signed [23:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 24'($urandom);
         1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
         2: return $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
         default: return $signed(24'($urandom_range(0, 524287))) - 24'sd262144;
      endcase
   endfunction

   function logic signed [15:0] pick_trig();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
   endfunction

   task random_op(int unsigned nv);
      int unsigned w;
      w = $urandom_range(0, 99);
      if (w < 40) send_item(MODE_QUERY, pick_coord(), pick_coord(), $urandom, $urandom, $urandom);
      else if (w < 60) send_item(MODE_READ, $urandom, $urandom, $urandom, $urandom,
                                 $urandom_range(0, 1) ? $urandom_range(0, nv) : $urandom);
      else if (w < 70) send_item(MODE_TRANSLATE, pick_coord() >>> $urandom_range(0, 12),
                                 pick_coord() >>> $urandom_range(0, 12), $urandom, $urandom,
                                 $urandom);
      else if (w < 80) send_item(MODE_ROTATE, pick_coord(), pick_coord(), pick_trig(),
                                 pick_trig(), $urandom);
      else if (w < 88) send_item(MODE_APPEND, pick_coord(), pick_coord(), $urandom, $urandom,
                                 $urandom);
      else if (w < 96) send_item(3'($urandom_range(6, 7)), $urandom, $urandom, $urandom,
                                 $urandom, $urandom);
      else send_item(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   initial begin
      int unsigned nv;
      sb = new();
      idle_on = 1'b1;
      stall_on = 1'b1;
      hold_off = 1'b0;
      sent = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= MODE_CLEAR;
      req_x_in <= '0;
      req_y_in <= '0;
      req_cos_val <= '0;
      req_sin_val <= '0;
      req_index <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_item(MODE_QUERY, 24'sd100, -24'sd100, 0, 0, 0);
      send_item(MODE_TRANSLATE, 24'sd5, 24'sd5, 0, 0, 0);
      send_item(MODE_ROTATE, 0, 0, 16'sd16384, 0, 0);
      send_item(MODE_READ, 0, 0, 0, 0, 6'd0);
      send_item(3'd6, 24'sh7FFFFF, 24'sh7FFFFF, 16'sh7FFF, 16'sh7FFF, 6'h3F);
      send_item(3'd7, 24'shFFFFFF, 24'shFFFFFF, 16'shFFFF, 16'shFFFF, 6'h3F);
      send_item(MODE_APPEND, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0);
      send_item(MODE_APPEND, 24'sh800000, 24'sh800000, 0, 0, 0);
      send_item(MODE_APPEND, 24'sh800000, 24'sh800000, 0, 0, 0);
      send_item(MODE_APPEND, 24'sh7FFFFF, 24'sh800000, 0, 0, 0);
      send_item(MODE_QUERY, 0, 0, 0, 0, 0);
      send_item(MODE_QUERY, 24'sh800000, 24'sh7FFFFF, 0, 0, 0);
      send_item(MODE_READ, 0, 0, 0, 0, 6'd3);
      send_item(MODE_READ, 0, 0, 0, 0, 6'd4);
      send_item(MODE_READ, 0, 0, 0, 0, 6'd63);
      send_item(MODE_TRANSLATE, 24'sh7FFFFF, 24'sh800000, 0, 0, 0);
      send_item(MODE_ROTATE, 24'sd256, -24'sd256, -16'sd16384, 16'sd16384, 0);
      send_item(MODE_QUERY, 24'sd1000, 24'sd2000, 0, 0, 0);
      send_item(MODE_CLEAR, 0, 0, 0, 0, 0);
      send_item(MODE_APPEND, 24'sd512, 24'sd512, 0, 0, 0);
      send_item(MODE_QUERY, 24'sd512, 24'sd512, 0, 0, 0);
      send_item(MODE_READ, 0, 0, 0, 0, 6'd0);

      while (sent < 580) begin
         if (sent > 250 && sent < 360) begin
            idle_on = 1'b0;
            stall_on = 1'b0;
         end else begin
            idle_on = 1'b1;
            stall_on = 1'b1;
         end
         if (sent > 200 && sent < 230 && !hold_off) hold_off = 1'b1;
         if (sent > 420 && sent < 440) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (sb.expected_q.size() != 0);
         end
         nv = ($urandom_range(0, 19) == 0) ? 64 : $urandom_range(1, 8);
         send_item(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
         for (int i = 0; i < nv; i++)
            send_item(MODE_APPEND, pick_coord(), pick_coord(), $urandom, $urandom, $urandom);
         if (nv == 64) begin
            send_item(MODE_APPEND, pick_coord(), pick_coord(), $urandom, $urandom, $urandom);
            send_item(MODE_QUERY, pick_coord(), pick_coord(), $urandom, $urandom, $urandom);
         end else begin
            repeat ($urandom_range(4, 12)) random_op(nv);
         end
      end
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_q.size() != 0);
      repeat (200) @(posedge clock);
      if (sb.errors == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end

endmodule
